### rtl/core/h2r_pkg.sv
// ============================================================================
// HSI to RGB conversion package
// Shared widths, constants and payload types of the HSI to RGB pipeline.
// ============================================================================
package h2r_pkg;

    localparam int HUE_W        = 16;
    localparam int FRAC_W       = 17;
    localparam int RGB_W        = 18;
    localparam int SECTOR_W     = 2;
    localparam int C255_W       = 24;
    localparam int ANG_W        = 19;
    localparam int CX_W         = 23;
    localparam int CORDIC_STEPS = 16;
    localparam int PROD_W       = 40;
    localparam int DVD_W        = 42;
    localparam int REM_W        = 41;
    localparam int DVS_W        = 23;
    localparam int DIV_STEPS    = 18;
    localparam int Q_W          = 19;
    localparam int EPROD_W      = 36;
    localparam int XP_W         = 40;
    localparam int MULT_W       = 34;
    localparam int HALF_W       = 17;
    localparam int PP_W         = 41;
    localparam int Q48_W        = 58;
    localparam int RND_SHIFT    = 40;

    localparam logic [FRAC_W-1:0]        ONE_Q16      = 17'd65536;
    localparam logic signed [CX_W-1:0]   CORDIC_START = 23'sd1048576;
    localparam logic signed [ANG_W-1:0]  ANG_HALF     = 19'sd32768;
    localparam logic signed [PROD_W-1:0] ROOT3_HALF   = 40'sd56756;
    localparam logic signed [Q_W-1:0]    Q_OFFSET     = 19'sd65536;
    localparam logic [DIV_STEPS-1:0]     Q_SPAN_MAX   = 18'd196608;
    localparam logic signed [EPROD_W-1:0] MULT_BIAS   = 36'sd4294967296;
    localparam logic [Q48_W-1:0]         ROUND_HALF   = Q48_W'(1) << (RND_SHIFT - 1);

    localparam logic [SECTOR_W-1:0] SEC_RED   = 2'd0;
    localparam logic [SECTOR_W-1:0] SEC_GREEN = 2'd1;
    localparam logic [SECTOR_W-1:0] SEC_BLUE  = 2'd2;

    // Arctangent of 2^-k in units where 65536 is 120 degrees.
    localparam logic signed [ANG_W-1:0] ATAN_UNITS [CORDIC_STEPS] = '{
        19'sd24576, 19'sd14508, 19'sd7666, 19'sd3891,
        19'sd1953,  19'sd978,   19'sd489,  19'sd244,
        19'sd122,   19'sd61,    19'sd31,   19'sd15,
        19'sd8,     19'sd4,     19'sd2,    19'sd1
    };

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [FRAC_W-1:0] saturation;
        logic [FRAC_W-1:0] intensity;
    } hsi_t;

    typedef struct packed {
        logic [RGB_W-1:0] red;
        logic [RGB_W-1:0] green;
        logic [RGB_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [FRAC_W-1:0]   sat;
        logic [C255_W-1:0]   c255;
        logic [SECTOR_W-1:0] sector;
    } side_t;

endpackage

### rtl/core/h2r_ratio.sv
// ============================================================================
// HSI to RGB sector ratio pipeline
// Computes cos(h)/cos(60deg-h) in Q16 with a pipelined CORDIC followed by a
// pipelined restoring divider, and carries the item's side data alongside.
// ============================================================================
module h2r_ratio
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic signed [h2r_pkg::ANG_W-1:0]     in_ang,
    input  h2r_pkg::side_t                       in_side,
    output logic                                 out_valid,
    output logic signed [h2r_pkg::Q_W-1:0]       out_q,
    output h2r_pkg::side_t                       out_side
);

    localparam int NC = h2r_pkg::CORDIC_STEPS;
    localparam int ND = h2r_pkg::DIV_STEPS;

    logic                                  c_vld_reg  [NC+1];
    logic signed [h2r_pkg::CX_W-1:0]       cx_reg     [NC+1];
    logic signed [h2r_pkg::CX_W-1:0]       sy_reg     [NC+1];
    logic signed [h2r_pkg::ANG_W-1:0]      ang_reg    [NC+1];
    h2r_pkg::side_t                        c_side_reg [NC+1];

    logic                                  m_vld_reg;
    logic signed [h2r_pkg::CX_W-1:0]       cxf_reg;
    logic signed [h2r_pkg::PROD_W-1:0]     prod_reg;
    h2r_pkg::side_t                        m_side_reg;

    logic                                  d_vld_reg  [ND+1];
    logic [h2r_pkg::REM_W-1:0]             rem_reg    [ND+1];
    logic [h2r_pkg::DVS_W-1:0]             dvs_reg    [ND+1];
    logic [h2r_pkg::DIV_STEPS-1:0]         quot_reg   [ND+1];
    logic                                  neg_reg    [ND+1];
    logic                                  ovf_reg    [1:ND];
    h2r_pkg::side_t                        d_side_reg [ND+1];

    logic                                  q_vld_reg;
    logic signed [h2r_pkg::Q_W-1:0]        q_reg;
    h2r_pkg::side_t                        q_side_reg;

    logic signed [h2r_pkg::CX_W-1:0]       cxf_next;
    logic signed [h2r_pkg::PROD_W-1:0]     sy_ext;
    logic signed [h2r_pkg::PROD_W-1:0]     prod_next;
    logic signed [h2r_pkg::DVD_W-1:0]      prod_ext;
    logic signed [h2r_pkg::DVD_W-1:0]      cx_ext;
    logic signed [h2r_pkg::DVD_W-1:0]      dvd_next;
    logic [h2r_pkg::DIV_STEPS-1:0]         qoff_next;
    logic signed [h2r_pkg::Q_W-1:0]        q_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg[0] <= 1'b0;
        end
        else
        begin
            c_vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg[0]     <= h2r_pkg::CORDIC_START;
        sy_reg[0]     <= '0;
        ang_reg[0]    <= in_ang;
        c_side_reg[0] <= in_side;
    end

    for (genvar k = 0; k < NC; k++)
    begin : g_cordic
        logic signed [h2r_pkg::CX_W-1:0] dx;
        logic signed [h2r_pkg::CX_W-1:0] dy;

        assign dx = sy_reg[k] >>> k;
        assign dy = cx_reg[k] >>> k;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                c_vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                c_vld_reg[k+1] <= c_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (!ang_reg[k][h2r_pkg::ANG_W-1])
            begin
                cx_reg[k+1]  <= cx_reg[k] - dx;
                sy_reg[k+1]  <= sy_reg[k] + dy;
                ang_reg[k+1] <= ang_reg[k] - h2r_pkg::ATAN_UNITS[k];
            end
            else
            begin
                cx_reg[k+1]  <= cx_reg[k] + dx;
                sy_reg[k+1]  <= sy_reg[k] - dy;
                ang_reg[k+1] <= ang_reg[k] + h2r_pkg::ATAN_UNITS[k];
            end
            c_side_reg[k+1] <= c_side_reg[k];
        end
    end

    // A cosine that is not positive is replaced by one LSB.
    always_comb
    begin
        cxf_next  = (cx_reg[NC] <= 0) ? h2r_pkg::CX_W'(1) : cx_reg[NC];
        sy_ext    = {{(h2r_pkg::PROD_W-h2r_pkg::CX_W){sy_reg[NC][h2r_pkg::CX_W-1]}},
                     sy_reg[NC]};
        prod_next = sy_ext * h2r_pkg::ROOT3_HALF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else
        begin
            m_vld_reg <= c_vld_reg[NC];
        end
    end

    always_ff @(posedge clk)
    begin
        cxf_reg    <= cxf_next;
        prod_reg   <= prod_next;
        m_side_reg <= c_side_reg[NC];
    end

    // The dividend is offset by one in Q16 so that the quotient is never
    // negative unless it must clamp at its lower bound.
    always_comb
    begin
        prod_ext = {{(h2r_pkg::DVD_W-h2r_pkg::PROD_W){prod_reg[h2r_pkg::PROD_W-1]}},
                    prod_reg};
        cx_ext   = {{(h2r_pkg::DVD_W-h2r_pkg::CX_W){cxf_reg[h2r_pkg::CX_W-1]}}, cxf_reg};
        dvd_next = (prod_ext <<< 1) + (cx_ext <<< 17) + (cx_ext <<< 16) + cx_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg[0] <= 1'b0;
        end
        else
        begin
            d_vld_reg[0] <= m_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg[0]    <= dvd_next[h2r_pkg::DVD_W-1];
        rem_reg[0]    <= dvd_next[h2r_pkg::DVD_W-1] ? '0 : dvd_next[h2r_pkg::REM_W-1:0];
        dvs_reg[0]    <= {cxf_reg[h2r_pkg::DVS_W-2:0], 1'b0};
        quot_reg[0]   <= '0;
        d_side_reg[0] <= m_side_reg;
    end

    for (genvar j = 0; j < ND; j++)
    begin : g_div
        logic [h2r_pkg::REM_W-1:0] trial;
        logic                      take;

        assign trial = h2r_pkg::REM_W'(dvs_reg[j]) << (ND - 1 - j);
        assign take  = (rem_reg[j] >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d_vld_reg[j+1] <= 1'b0;
            end
            else
            begin
                d_vld_reg[j+1] <= d_vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j+1]    <= take ? (rem_reg[j] - trial) : rem_reg[j];
            quot_reg[j+1]   <= {quot_reg[j][h2r_pkg::DIV_STEPS-2:0], take};
            dvs_reg[j+1]    <= dvs_reg[j];
            neg_reg[j+1]    <= neg_reg[j];
            d_side_reg[j+1] <= d_side_reg[j];
        end

        if (j == 0)
        begin : g_ovf_first
            always_ff @(posedge clk)
            begin
                ovf_reg[1] <= (rem_reg[0] >= (h2r_pkg::REM_W'(dvs_reg[0]) << ND));
            end
        end
        else
        begin : g_ovf_carry
            always_ff @(posedge clk)
            begin
                ovf_reg[j+1] <= ovf_reg[j];
            end
        end
    end

    always_comb
    begin
        if (neg_reg[ND])
        begin
            qoff_next = '0;
        end
        else if (ovf_reg[ND] || (quot_reg[ND] > h2r_pkg::Q_SPAN_MAX))
        begin
            qoff_next = h2r_pkg::Q_SPAN_MAX;
        end
        else
        begin
            qoff_next = quot_reg[ND];
        end
        q_next = $signed({1'b0, qoff_next}) - h2r_pkg::Q_OFFSET;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_vld_reg <= 1'b0;
        end
        else
        begin
            q_vld_reg <= d_vld_reg[ND];
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg      <= q_next;
        q_side_reg <= d_side_reg[ND];
    end

    assign out_valid = q_vld_reg;
    assign out_q     = q_reg;
    assign out_side  = q_side_reg;

endmodule

### rtl/core/h2r_mix.sv
// ============================================================================
// HSI to RGB component mixer
// Forms x, y and z from the sector ratio, rounds them to Q8 and routes them
// to red, green and blue by sector, in six register stages.
// ============================================================================
module h2r_mix
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic signed [h2r_pkg::Q_W-1:0]    in_q,
    input  h2r_pkg::side_t                    in_side,
    output logic                              out_valid,
    output h2r_pkg::rgb_t                     out_rgb
);

    localparam int QW  = h2r_pkg::Q48_W;
    localparam int EW  = h2r_pkg::EPROD_W;
    localparam int SW  = h2r_pkg::SECTOR_W;
    localparam int CW  = h2r_pkg::C255_W;
    localparam int RW  = h2r_pkg::RGB_W;

    logic                              p1_vld_reg;
    logic signed [EW-1:0]              e_reg;
    logic [h2r_pkg::XP_W-1:0]          p1_xp_reg;
    logic [CW-1:0]                     p1_c255_reg;
    logic [SW-1:0]                     p1_sec_reg;

    logic                              p2_vld_reg;
    logic [h2r_pkg::MULT_W-1:0]        mult_reg;
    logic [h2r_pkg::XP_W-1:0]          p2_xp_reg;
    logic [CW-1:0]                     p2_c255_reg;
    logic [SW-1:0]                     p2_sec_reg;

    logic                              p3_vld_reg;
    logic [h2r_pkg::PP_W-1:0]          ph_reg;
    logic [h2r_pkg::PP_W-1:0]          pl_reg;
    logic [h2r_pkg::XP_W-1:0]          p3_xp_reg;
    logic [CW-1:0]                     p3_c255_reg;
    logic [SW-1:0]                     p3_sec_reg;

    logic                              p4_vld_reg;
    logic [QW-1:0]                     xq_reg;
    logic [QW-1:0]                     yq_reg;
    logic [QW-1:0]                     tot_reg;
    logic [SW-1:0]                     p4_sec_reg;

    logic                              p5_vld_reg;
    logic [RW-1:0]                     xv_reg;
    logic [RW-1:0]                     yv_reg;
    logic [QW-1:0]                     zq_reg;
    logic [SW-1:0]                     p5_sec_reg;

    logic                              p6_vld_reg;
    h2r_pkg::rgb_t                     rgb_reg;

    logic [h2r_pkg::FRAC_W-1:0]        omsat;
    logic signed [EW-1:0]              sat_s;
    logic signed [EW-1:0]              q_s;
    logic signed [EW-1:0]              e_next;
    logic [h2r_pkg::XP_W-1:0]          xp_next;
    logic signed [EW-1:0]              mult_s;
    logic [h2r_pkg::MULT_W-1:0]        mult_next;
    logic [h2r_pkg::PP_W-1:0]          ph_next;
    logic [h2r_pkg::PP_W-1:0]          pl_next;
    logic [CW+1:0]                     c3;
    logic signed [QW+1:0]              diff;
    logic [QW-1:0]                     xr;
    logic [QW-1:0]                     yr;
    logic [QW-1:0]                     zr;
    logic [RW-1:0]                     zv;
    h2r_pkg::rgb_t                     rgb_next;

    always_comb
    begin
        omsat   = h2r_pkg::ONE_Q16 - in_side.sat;
        sat_s   = $signed({{(EW-h2r_pkg::FRAC_W){1'b0}}, in_side.sat});
        q_s     = $signed({{(EW-h2r_pkg::Q_W){in_q[h2r_pkg::Q_W-1]}}, in_q});
        e_next  = sat_s * q_s;
        xp_next = {{(h2r_pkg::XP_W-CW){1'b0}}, in_side.c255}
                * {{(h2r_pkg::XP_W-h2r_pkg::FRAC_W){1'b0}}, omsat};
    end

    always_comb
    begin
        mult_s    = h2r_pkg::MULT_BIAS + e_reg;
        mult_next = mult_s[EW-1] ? '0 : mult_s[h2r_pkg::MULT_W-1:0];
    end

    always_comb
    begin
        ph_next = {{(h2r_pkg::PP_W-CW){1'b0}}, p2_c255_reg}
                * {{(h2r_pkg::PP_W-h2r_pkg::HALF_W){1'b0}},
                   mult_reg[h2r_pkg::MULT_W-1:h2r_pkg::HALF_W]};
        pl_next = {{(h2r_pkg::PP_W-CW){1'b0}}, p2_c255_reg}
                * {{(h2r_pkg::PP_W-h2r_pkg::HALF_W){1'b0}},
                   mult_reg[h2r_pkg::HALF_W-1:0]};
        c3      = {2'b00, p3_c255_reg} + {1'b0, p3_c255_reg, 1'b0};
    end

    // The third component is whatever remains of three times c; it is held
    // at zero should the other two exceed that.
    always_comb
    begin
        diff = $signed({2'b00, tot_reg}) - $signed({2'b00, xq_reg})
             - $signed({2'b00, yq_reg});
        xr   = xq_reg + h2r_pkg::ROUND_HALF;
        yr   = yq_reg + h2r_pkg::ROUND_HALF;
    end

    always_comb
    begin
        zr = zq_reg + h2r_pkg::ROUND_HALF;
        zv = zr[QW-1:h2r_pkg::RND_SHIFT];
        case (p5_sec_reg)
            h2r_pkg::SEC_GREEN:
            begin
                rgb_next.red   = xv_reg;
                rgb_next.green = yv_reg;
                rgb_next.blue  = zv;
            end
            h2r_pkg::SEC_BLUE:
            begin
                rgb_next.green = xv_reg;
                rgb_next.blue  = yv_reg;
                rgb_next.red   = zv;
            end
            default:
            begin
                rgb_next.blue  = xv_reg;
                rgb_next.red   = yv_reg;
                rgb_next.green = zv;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            p4_vld_reg <= 1'b0;
            p5_vld_reg <= 1'b0;
            p6_vld_reg <= 1'b0;
        end
        else
        begin
            p1_vld_reg <= in_valid;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
            p4_vld_reg <= p3_vld_reg;
            p5_vld_reg <= p4_vld_reg;
            p6_vld_reg <= p5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg       <= e_next;
        p1_xp_reg   <= xp_next;
        p1_c255_reg <= in_side.c255;
        p1_sec_reg  <= in_side.sector;

        mult_reg    <= mult_next;
        p2_xp_reg   <= p1_xp_reg;
        p2_c255_reg <= p1_c255_reg;
        p2_sec_reg  <= p1_sec_reg;

        ph_reg      <= ph_next;
        pl_reg      <= pl_next;
        p3_xp_reg   <= p2_xp_reg;
        p3_c255_reg <= p2_c255_reg;
        p3_sec_reg  <= p2_sec_reg;

        yq_reg      <= {ph_reg, {h2r_pkg::HALF_W{1'b0}}}
                     + {{(QW-h2r_pkg::PP_W){1'b0}}, pl_reg};
        xq_reg      <= {2'b00, p3_xp_reg, 16'd0};
        tot_reg     <= {c3, 32'd0};
        p4_sec_reg  <= p3_sec_reg;

        xv_reg      <= xr[QW-1:h2r_pkg::RND_SHIFT];
        yv_reg      <= yr[QW-1:h2r_pkg::RND_SHIFT];
        zq_reg      <= diff[QW+1] ? '0 : diff[QW-1:0];
        p5_sec_reg  <= p4_sec_reg;

        rgb_reg     <= rgb_next;
    end

    assign out_valid = p6_vld_reg;
    assign out_rgb   = rgb_reg;

endmodule

### rtl/core/hsi_to_rgb_convert_unit.sv
// ============================================================================
// HSI to RGB conversion unit
// Converts one HSI pixel per clock to unclamped Q8 red, green and blue.
// ============================================================================
// Usage:
// An item is a pixel on hsi (hue as a fraction of a turn, saturation and
// intensity in Q16, both clamped to 1.0). It is taken at every rising edge
// at which start is high and busy is low. The unit is fully pipelined, so
// busy always stays low and a new item may be given in every cycle.
// Each item yields one result on rgb, shown for exactly one cycle while
// done is high. The result passes through one input stage, sixteen
// CORDIC stages, a multiply stage, a dividend stage, eighteen divider
// stages, a clamp stage and six stages that form, round and route the
// components. The eighteen-stage restoring divider is the longest part.
// Throughput is one item per cycle.
// Results leave in the order their items came in. The receiver cannot
// hold results off and the unit never needs it to.
// Reset clears all valid bits at once; no result is pending after it.
// ============================================================================
module hsi_to_rgb_convert_unit
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  h2r_pkg::hsi_t   hsi,
    output logic            done,
    output h2r_pkg::rgb_t   rgb
);

    logic [h2r_pkg::FRAC_W-1:0]         sat_clamp;
    logic [h2r_pkg::FRAC_W-1:0]         int_clamp;
    logic [h2r_pkg::C255_W:0]           c255_wide;
    logic [h2r_pkg::HUE_W+1:0]          h3;
    logic signed [h2r_pkg::ANG_W-1:0]   ang;
    h2r_pkg::side_t                     side;
    logic                               ratio_valid;
    logic signed [h2r_pkg::Q_W-1:0]     ratio_q;
    h2r_pkg::side_t                     ratio_side;

    always_comb
    begin
        sat_clamp = (hsi.saturation > h2r_pkg::ONE_Q16) ? h2r_pkg::ONE_Q16
                                                        : hsi.saturation;
        int_clamp = (hsi.intensity > h2r_pkg::ONE_Q16) ? h2r_pkg::ONE_Q16
                                                       : hsi.intensity;
        c255_wide = {int_clamp, 8'd0} - {8'd0, int_clamp};
        h3        = {1'b0, hsi.hue, 1'b0} + {2'b00, hsi.hue};
        ang       = h2r_pkg::ANG_HALF - $signed({3'b000, h3[h2r_pkg::HUE_W-1:0]});

        side.sat    = sat_clamp;
        side.c255   = c255_wide[h2r_pkg::C255_W-1:0];
        side.sector = h3[h2r_pkg::HUE_W+1:h2r_pkg::HUE_W];
    end

    assign busy = 1'b0;

    h2r_ratio u_ratio
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .in_ang    (ang),
        .in_side   (side),
        .out_valid (ratio_valid),
        .out_q     (ratio_q),
        .out_side  (ratio_side)
    );

    h2r_mix u_mix
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ratio_valid),
        .in_q      (ratio_q),
        .in_side   (ratio_side),
        .out_valid (done),
        .out_rgb   (rgb)
    );

endmodule
